### src/ntd_pkg.sv
// ----------------------------------------------------------------------------
// ntd_pkg
// Shared types, constants and helpers of the n-tuple TD value engine.
// ----------------------------------------------------------------------------
package ntd_pkg;

  localparam int DEF_TUPLE_LEN  = 4;
  localparam int DEF_NUM_TUPLES = 4;
  localparam int DEF_CELL_BASE  = 22;

  localparam int NUM_CELLS = 16;
  localparam int CODE_W    = 5;
  localparam int NUM_SYM   = 8;
  localparam int FRAC_W    = 16;
  localparam int DEN_SHIFT = 19;   // 8 symmetries * 2^16

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [15:0] RST_LR    = 16'd6554;
  localparam logic [2:0]  RST_TC    = 3'd4;
  localparam logic        RST_TE    = 1'b1;
  localparam logic [15:0] RST_CELLS_A = 16'd291;
  localparam logic [15:0] RST_CELLS_B = 16'd18023;
  localparam logic [15:0] RST_CELLS_C = 16'd35243;
  localparam logic [15:0] RST_CELLS_D = 16'd52719;

  typedef enum logic [2:0] {
    REG_LEARN_RATE  = 3'd0,
    REG_TUPLE_COUNT = 3'd1,
    REG_TRAIN_EN    = 3'd2,
    REG_CELLS_A     = 3'd3,
    REG_CELLS_B     = 3'd4,
    REG_CELLS_C     = 3'd5,
    REG_CELLS_D     = 3'd6,
    REG_UNUSED      = 3'd7
  } reg_idx_t;

  typedef logic [15:0] cells_t [4];

  // controller -> datapath
  typedef struct packed {
    logic clr_wr;
    logic load;
    logic it_rst;
    logic it_adv;
    logic rd;
    logic acc_clr;
    logic acc_add;
    logic latch_before;
    logic latch_after;
    logic err_calc;
    logic mul;
    logic mul_mv;
    logic div_start;
    logic div_mv;
    logic scaled_latch;
    logic mv_latch;
    logic wr;
    logic nv_update;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic it_last;
    logic ab_zero;
    logic div_done;
    logic train;
  } stat_t;

  function automatic longint span_of(input int tl, input int base);
    longint s;
    s = 1;
    for (int i = 0; i < tl; i++) s = s * base;
    return s;
  endfunction

endpackage

### src/ntd_if.sv
// ----------------------------------------------------------------------------
// ntd_in_if / ntd_out_if
// Valid/ready channels for boards in and values out.
// ----------------------------------------------------------------------------
interface ntd_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [39:0] board_low;
  logic [39:0] board_high;
  logic [23:0] reward;
  logic        episode_end;

  modport source (output valid, op, board_low, board_high, reward, episode_end,
                  input ready);
  modport sink   (input valid, op, board_low, board_high, reward, episode_end,
                  output ready);
endinterface

interface ntd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value_before;
  logic signed [31:0] value_after;
  logic signed [31:0] error_applied;

  modport source (output valid, value_before, value_after, error_applied,
                  input ready);
  modport sink   (input valid, value_before, value_after, error_applied,
                  output ready);
endinterface

### src/ntd_cfg.sv
// ----------------------------------------------------------------------------
// ntd_cfg
// APB-style register file; also clamps the tuple count.
// ----------------------------------------------------------------------------
module ntd_cfg #(
  parameter int NUM_TUPLES = ntd_pkg::DEF_NUM_TUPLES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ntd_pkg::PADDR_W-1:0] paddr,
  input  logic [ntd_pkg::PDATA_W-1:0] pwdata,
  output logic [ntd_pkg::PDATA_W-1:0] prdata,
  output logic [15:0]                 learn_rate,
  output logic [2:0]                  count_eff,
  output logic                        train_en,
  output ntd_pkg::cells_t             cells
);

  logic [15:0] lr_r;
  logic [2:0]  tc_r;
  logic        te_r;
  logic [15:0] cells_r [4];
  ntd_pkg::reg_idx_t idx;
  logic        wr_en;

  assign idx   = ntd_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r       <= ntd_pkg::RST_LR;
      tc_r       <= ntd_pkg::RST_TC;
      te_r       <= ntd_pkg::RST_TE;
      cells_r[0] <= ntd_pkg::RST_CELLS_A;
      cells_r[1] <= ntd_pkg::RST_CELLS_B;
      cells_r[2] <= ntd_pkg::RST_CELLS_C;
      cells_r[3] <= ntd_pkg::RST_CELLS_D;
    end else if (wr_en) begin
      unique case (idx)
        ntd_pkg::REG_LEARN_RATE:  lr_r       <= pwdata[15:0];
        ntd_pkg::REG_TUPLE_COUNT: tc_r       <= pwdata[2:0];
        ntd_pkg::REG_TRAIN_EN:    te_r       <= pwdata[0];
        ntd_pkg::REG_CELLS_A:     cells_r[0] <= pwdata[15:0];
        ntd_pkg::REG_CELLS_B:     cells_r[1] <= pwdata[15:0];
        ntd_pkg::REG_CELLS_C:     cells_r[2] <= pwdata[15:0];
        ntd_pkg::REG_CELLS_D:     cells_r[3] <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ntd_pkg::REG_LEARN_RATE:  prdata = {16'd0, lr_r};
      ntd_pkg::REG_TUPLE_COUNT: prdata = {29'd0, tc_r};
      ntd_pkg::REG_TRAIN_EN:    prdata = {31'd0, te_r};
      ntd_pkg::REG_CELLS_A:     prdata = {16'd0, cells_r[0]};
      ntd_pkg::REG_CELLS_B:     prdata = {16'd0, cells_r[1]};
      ntd_pkg::REG_CELLS_C:     prdata = {16'd0, cells_r[2]};
      ntd_pkg::REG_CELLS_D:     prdata = {16'd0, cells_r[3]};
      default:                  prdata = '0;
    endcase
  end

  always_comb begin
    if (tc_r == 3'd0)                  count_eff = 3'd1;
    else if (32'(tc_r) > NUM_TUPLES)   count_eff = 3'(NUM_TUPLES);
    else                               count_eff = tc_r;
  end

  assign learn_rate = lr_r;
  assign train_en   = te_r;
  assign cells      = cells_r;

endmodule

### src/ntd_div.sv
// ----------------------------------------------------------------------------
// ntd_div
// Unsigned 64 / 32 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ntd_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic [63:0] quotient,
  output logic        done
);

  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [31:0] rem_r;
  logic [63:0] q_r;
  logic [31:0] dvs_r;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;

  assign rem_sh  = {rem_r, q_r[63]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd64;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (!rem_sub[32]) begin
        rem_r <= rem_sub[31:0];
        q_r   <= {q_r[62:0], 1'b1};
      end else begin
        rem_r <= rem_sh[31:0];
        q_r   <= {q_r[62:0], 1'b0};
      end
    end
  end

  assign quotient = q_r;
  assign done     = done_r;

endmodule

### src/ntd_dp.sv
// ----------------------------------------------------------------------------
// ntd_dp
// Datapath: board latch, tuple address generator, weight/error tables,
// accumulator, shared multiplier and divider, output registers.
// ----------------------------------------------------------------------------
module ntd_dp #(
  parameter int TUPLE_LEN  = ntd_pkg::DEF_TUPLE_LEN,
  parameter int NUM_TUPLES = ntd_pkg::DEF_NUM_TUPLES,
  parameter int CELL_BASE  = ntd_pkg::DEF_CELL_BASE
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ntd_pkg::cmd_t      cmd,
  output ntd_pkg::stat_t     stat,
  input  logic [15:0]        learn_rate,
  input  logic [2:0]         count_eff,
  input  logic               train_en,
  input  ntd_pkg::cells_t    cells,
  input  logic               in_op,
  input  logic [39:0]        in_board_low,
  input  logic [39:0]        in_board_high,
  input  logic [23:0]        in_reward,
  input  logic               in_episode_end,
  output logic signed [31:0] out_value_before,
  output logic signed [31:0] out_value_after,
  output logic signed [31:0] out_error_applied
);

  localparam longint SPAN  = ntd_pkg::span_of(TUPLE_LEN, CELL_BASE);
  localparam longint DEPTH = longint'(NUM_TUPLES) * SPAN;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int K_W    = (NUM_TUPLES > 1) ? $clog2(NUM_TUPLES) : 1;
  localparam int ACC_W  = 32 + $clog2(NUM_TUPLES * ntd_pkg::NUM_SYM) + 1;
  localparam int CW     = ntd_pkg::CODE_W;

  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(-64'sd2147483648);
  localparam logic signed [42:0] T_MAX = 43'sd2147483647;
  localparam logic signed [42:0] T_MIN = -43'sd2147483648;

  // board and item
  logic [CW-1:0] code_r [ntd_pkg::NUM_CELLS];
  logic          op_r;
  logic [23:0]   reward_r;
  logic          end_r;

  // iteration
  logic [K_W-1:0] k_r;
  logic [2:0]     s_r;
  logic [3:0]     perm_r [ntd_pkg::NUM_CELLS];

  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] mem_addr;
  logic [ADDR_W-1:0] clr_cnt_r;

  // tables
  logic [31:0] w_mem [0:DEPTH-1];
  logic [31:0] e_mem [0:DEPTH-1];
  logic [31:0] a_mem [0:DEPTH-1];
  logic signed [31:0] w_q, e_q;
  logic [31:0]        a_q;

  // arithmetic
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [31:0] acc_sat;
  logic signed [31:0] vb_r, va_r, err_r, scaled_r, mv_r;
  logic signed [31:0] nv_r;
  logic [23:0]        nr_r;
  logic signed [42:0] tgt, diff;
  logic [31:0] mag_err, mag_scaled, mag_e, mul_a, mul_b;
  logic [63:0] prod_r;
  logic [31:0] dvs;
  logic [63:0] div_q;
  logic        div_done;
  logic signed [31:0] q_lo, mv_use;
  logic signed [32:0] w_sum, e_sum;
  logic [32:0]        a_sum;
  logic signed [31:0] w_new, e_new;
  logic [31:0]        a_new;

  // ---- address generation: tuple digits read through the current symmetry
  always_comb begin
    logic [15:0]       csel;
    logic [3:0]        pos;
    logic [ADDR_W-1:0] f;
    csel = cells[2'(k_r)];
    f    = '0;
    for (int i = 0; i < TUPLE_LEN; i++) begin
      pos = 4'(csel >> (4 * (TUPLE_LEN - 1 - i)));
      f   = ADDR_W'(longint'(f) * CELL_BASE) + ADDR_W'(code_r[perm_r[pos]]);
    end
    cur_addr = ADDR_W'(longint'(k_r) * SPAN) + f;
  end

  assign mem_addr = cmd.clr_wr ? clr_cnt_r : cur_addr;

  always_ff @(posedge clk) begin
    logic [3:0] np [ntd_pkg::NUM_CELLS];
    if (!rst_n) begin
      k_r <= '0;
      s_r <= '0;
      for (int i = 0; i < ntd_pkg::NUM_CELLS; i++) perm_r[i] <= 4'(i);
    end else if (cmd.it_rst) begin
      k_r <= '0;
      s_r <= '0;
      for (int i = 0; i < ntd_pkg::NUM_CELLS; i++) perm_r[i] <= 4'(i);
    end else if (cmd.it_adv) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          if (s_r == 3'd3) np[r*4+c] = perm_r[(3-r)*4+c];
          else             np[r*4+c] = perm_r[(3-c)*4+r];
        end
      end
      if (s_r == 3'd7) begin
        k_r <= k_r + K_W'(1);
        s_r <= '0;
        for (int i = 0; i < ntd_pkg::NUM_CELLS; i++) perm_r[i] <= 4'(i);
      end else begin
        s_r <= s_r + 3'd1;
        for (int i = 0; i < ntd_pkg::NUM_CELLS; i++) perm_r[i] <= np[i];
      end
    end
  end

  assign stat.it_last = (s_r == 3'd7) && ((32'(k_r) + 32'd1) == 32'(count_eff));

  // ---- clear sweep
  always_ff @(posedge clk) begin
    if (!rst_n)           clr_cnt_r <= '0;
    else if (cmd.clr_wr)  clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
  end

  assign stat.clr_last = (clr_cnt_r == ADDR_W'(DEPTH - 1));

  // ---- tables
  always_ff @(posedge clk) begin
    if (cmd.clr_wr || cmd.wr) begin
      w_mem[mem_addr] <= cmd.clr_wr ? 32'd0 : w_new;
      e_mem[mem_addr] <= cmd.clr_wr ? 32'd0 : e_new;
      a_mem[mem_addr] <= cmd.clr_wr ? 32'd0 : a_new;
    end
    if (cmd.rd) begin
      w_q <= w_mem[mem_addr];
      e_q <= e_mem[mem_addr];
      a_q <= a_mem[mem_addr];
    end
  end

  assign stat.ab_zero = (a_q == 32'd0);

  // ---- item latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < ntd_pkg::NUM_CELLS; i++) begin
        logic [CW-1:0] c;
        c = (i < 8) ? in_board_low[CW*i +: CW] : in_board_high[CW*(i-8) +: CW];
        code_r[i] <= (32'(c) >= CELL_BASE) ? CW'(CELL_BASE - 1) : c;
      end
      op_r     <= in_op;
      reward_r <= in_reward;
      end_r    <= in_episode_end;
    end
  end

  assign stat.train = op_r && train_en;

  // ---- accumulator
  assign acc_nxt = acc_r + ACC_W'(w_q);
  always_comb begin
    if (acc_nxt > ACC_MAX)      acc_sat = 32'sh7fffffff;
    else if (acc_nxt < ACC_MIN) acc_sat = 32'sh80000000;
    else                        acc_sat = 32'(acc_nxt);
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr)      acc_r <= '0;
    else if (cmd.acc_add) acc_r <= acc_nxt;
    if (cmd.latch_before) vb_r <= acc_sat;
    if (cmd.latch_after)  va_r <= acc_sat;
  end

  // ---- TD error
  assign tgt  = end_r ? 43'sd0 : (43'(nv_r) + $signed({3'd0, nr_r, 16'd0}));
  assign diff = tgt - 43'(vb_r);

  assign mag_err    = err_r[31]    ? 32'd0 - 32'(err_r)    : 32'(err_r);
  assign mag_scaled = scaled_r[31] ? 32'd0 - 32'(scaled_r) : 32'(scaled_r);
  assign mag_e      = e_q[31]      ? 32'd0 - 32'(e_q)      : 32'(e_q);
  assign mul_a      = cmd.mul_mv ? mag_scaled : mag_err;
  assign mul_b      = cmd.mul_mv ? mag_e : {16'd0, learn_rate};

  always_ff @(posedge clk) begin
    if (cmd.err_calc) begin
      if (diff > T_MAX)      err_r <= 32'sh7fffffff;
      else if (diff < T_MIN) err_r <= 32'sh80000000;
      else                   err_r <= 32'(diff);
    end
    if (cmd.mul) prod_r <= 64'(mul_a) * 64'(mul_b);
  end

  assign dvs = cmd.div_mv ? a_q : (32'(count_eff) << ntd_pkg::DEN_SHIFT);

  ntd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (dvs),
    .quotient (div_q),
    .done     (div_done)
  );

  assign stat.div_done = div_done;
  assign q_lo = $signed(div_q[31:0]);

  always_ff @(posedge clk) begin
    if (cmd.load)              scaled_r <= '0;
    else if (cmd.scaled_latch) scaled_r <= err_r[31] ? -q_lo : q_lo;
    if (cmd.mv_latch)          mv_r     <= scaled_r[31] ? -q_lo : q_lo;
  end

  // ---- weight update
  assign mv_use = stat.ab_zero ? scaled_r : mv_r;
  assign w_sum  = 33'(w_q) + 33'(mv_use);
  assign e_sum  = 33'(e_q) + 33'(scaled_r);
  assign a_sum  = {1'b0, a_q} + {1'b0, mag_scaled};

  always_comb begin
    if (w_sum[32] != w_sum[31]) w_new = w_sum[32] ? 32'sh80000000 : 32'sh7fffffff;
    else                        w_new = w_sum[31:0];
    if (e_sum[32] != e_sum[31]) e_new = e_sum[32] ? 32'sh80000000 : 32'sh7fffffff;
    else                        e_new = e_sum[31:0];
    a_new = a_sum[32] ? 32'hffffffff : a_sum[31:0];
  end

  // ---- carried state and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= '0;
      nr_r <= '0;
    end else if (cmd.nv_update) begin
      nv_r <= va_r;
      nr_r <= reward_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value_before  <= vb_r;
      out_value_after   <= va_r;
      out_error_applied <= scaled_r;
    end
  end

endmodule

### src/ntd_ctrl.sv
// ----------------------------------------------------------------------------
// ntd_ctrl
// Sequencer: clear sweep, evaluate passes, error scaling, per-weight update.
// ----------------------------------------------------------------------------
module ntd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output ntd_pkg::cmd_t  cmd,
  input  ntd_pkg::stat_t stat
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EV_RD, S_EV_ACC, S_ERR, S_MUL, S_DIV_S, S_DIV_W,
    S_UP_RD, S_UP_MUL, S_UP_DIV, S_UP_DW, S_UP_WR, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   pass_r, pass_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          cmd.it_rst  = 1'b1;
          cmd.acc_clr = 1'b1;
          pass_nxt    = 1'b0;
          state_nxt   = S_EV_RD;
        end
      end
      S_EV_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EV_ACC;
      end
      S_EV_ACC: begin
        cmd.acc_add = 1'b1;
        if (stat.it_last) begin
          if (pass_r) begin
            cmd.latch_after = 1'b1;
            state_nxt       = S_DONE;
          end else begin
            cmd.latch_before = 1'b1;
            if (stat.train) begin
              state_nxt = S_ERR;
            end else begin
              cmd.latch_after = 1'b1;
              state_nxt       = S_DONE;
            end
          end
        end else begin
          cmd.it_adv = 1'b1;
          state_nxt  = S_EV_RD;
        end
      end
      S_ERR: begin
        cmd.err_calc = 1'b1;
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV_S;
      end
      S_DIV_S: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_W;
      end
      S_DIV_W: begin
        if (stat.div_done) begin
          cmd.scaled_latch = 1'b1;
          cmd.it_rst       = 1'b1;
          state_nxt        = S_UP_RD;
        end
      end
      S_UP_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_UP_MUL;
      end
      S_UP_MUL: begin
        cmd.mul    = 1'b1;
        cmd.mul_mv = 1'b1;
        state_nxt  = stat.ab_zero ? S_UP_WR : S_UP_DIV;
      end
      S_UP_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_mv    = 1'b1;
        state_nxt     = S_UP_DW;
      end
      S_UP_DW: begin
        if (stat.div_done) begin
          cmd.mv_latch = 1'b1;
          state_nxt    = S_UP_WR;
        end
      end
      S_UP_WR: begin
        cmd.wr = 1'b1;
        if (stat.it_last) begin
          cmd.it_rst  = 1'b1;
          cmd.acc_clr = 1'b1;
          pass_nxt    = 1'b1;
        end else begin
          cmd.it_adv = 1'b1;
        end
        state_nxt = stat.it_last ? S_EV_RD : S_UP_RD;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          cmd.nv_update = pass_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### src/ntuple_td_value_engine.sv
// ----------------------------------------------------------------------------
// ntuple_td_value_engine
// N-tuple board evaluator with temporal-coherence TD training.
// ----------------------------------------------------------------------------
// Evaluate: a read and an accumulate per weight (32 reads at 4 tuples), then
//   the result load; the next input is taken the cycle after the result loads.
// Train: evaluate pass, error scaling through multiplier and divider, per weight
//   a read, multiply and write, plus a divide when its |error| sum is nonzero, then a second pass.
// Reset: a clearing pass writes zero to every table entry, one per cycle,
//   4*22^4 = 937024 entries at default parameters; no input taken meanwhile.
// ----------------------------------------------------------------------------
module ntuple_td_value_engine #(
  parameter int TUPLE_LEN  = ntd_pkg::DEF_TUPLE_LEN,
  parameter int NUM_TUPLES = ntd_pkg::DEF_NUM_TUPLES,
  parameter int CELL_BASE  = ntd_pkg::DEF_CELL_BASE
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ntd_in_if.sink                      in_chan,
  ntd_out_if.source                   out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ntd_pkg::PADDR_W-1:0] paddr,
  input  logic [ntd_pkg::PDATA_W-1:0] pwdata,
  output logic [ntd_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  ntd_pkg::cmd_t   cmd;
  ntd_pkg::stat_t  stat;
  ntd_pkg::cells_t cells;
  logic [15:0]     learn_rate;
  logic [2:0]      count_eff;
  logic            train_en;

  // register writes never stall
  assign pready = 1'b1;

  ntd_cfg #(.NUM_TUPLES(NUM_TUPLES)) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .learn_rate (learn_rate),
    .count_eff  (count_eff),
    .train_en   (train_en),
    .cells      (cells)
  );

  // sequencer: owns the handshake and the output-valid flag
  ntd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // datapath: tables, address generator, arithmetic, result registers
  ntd_dp #(
    .TUPLE_LEN  (TUPLE_LEN),
    .NUM_TUPLES (NUM_TUPLES),
    .CELL_BASE  (CELL_BASE)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .learn_rate        (learn_rate),
    .count_eff         (count_eff),
    .train_en          (train_en),
    .cells             (cells),
    .in_op             (in_chan.op),
    .in_board_low      (in_chan.board_low),
    .in_board_high     (in_chan.board_high),
    .in_reward         (in_chan.reward),
    .in_episode_end    (in_chan.episode_end),
    .out_value_before  (out_chan.value_before),
    .out_value_after   (out_chan.value_after),
    .out_error_applied (out_chan.error_applied)
  );

endmodule

### sim/ntuple_td_value_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ntuple_td_value_engine_tb
// Self-checking bench: drives boards through the valid/ready input channel,
// predicts value_before / value_after / error_applied with its own sparse
// model of the weight and coherence tables, and compares each result
// transaction in order. Configuration moves through several settings over APB.
// ----------------------------------------------------------------------------
module ntuple_td_value_engine_tb;

  localparam int SPAN_T  = 22 * 22 * 22 * 22;   // entries per tuple
  localparam int HOLD_CY = 3000;                // long receiver hold-off

  typedef struct {
    int before_v;
    int after_v;
    int err_v;
  } td_result_t;

  typedef struct {
    bit          op;
    logic [39:0] lo;
    logic [39:0] hi;
    logic [23:0] rw;
    bit          ep;
    bit          fixed;     // expectation typed in below
    td_result_t  res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ntd_pkg::PADDR_W-1:0] paddr = '0;
  logic [ntd_pkg::PDATA_W-1:0] pwdata = '0;
  logic [ntd_pkg::PDATA_W-1:0] prdata;
  logic pready;

  ntd_in_if  in_if ();
  ntd_out_if out_if ();

  ntuple_td_value_engine dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_if), .out_chan(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #1_000_000_000;
    $display("ntuple_td_value_engine test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Shadow configuration and learner state
  // --------------------------------------------------------------------------
  logic [15:0] rate_q = ntd_pkg::RST_LR;
  logic [2:0]  count_q = ntd_pkg::RST_TC;
  logic        train_q = ntd_pkg::RST_TE;
  logic [15:0] cells_q [4] = '{ntd_pkg::RST_CELLS_A, ntd_pkg::RST_CELLS_B,
                               ntd_pkg::RST_CELLS_C, ntd_pkg::RST_CELLS_D};
  int          next_val_q = 0;
  logic [23:0] next_rw_q = '0;

  // sparse tables; an absent key is a cleared entry
  int          weight_mem [int];
  int          coh_err_mem [int];
  int unsigned coh_abs_mem [int];

  int          sym_perm [8][16];   // cell map per symmetry
  td_result_t  pending_q [$];      // results still owed by the block
  int          mismatches = 0;
  bit          hold_req = 1'b0;
  int          burst_left = 0;

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  // identity, three clockwise turns, flip, then three more turns
  function automatic void build_sym_perm();
    int p [16];
    int np [16];
    for (int i = 0; i < 16; i++) p[i] = i;
    for (int s = 0; s < 8; s++) begin
      sym_perm[s] = p;
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          np[r*4+c] = (s == 3) ? p[(3-r)*4+c] : p[(3-c)*4+r];
      p = np;
    end
  endfunction

  function automatic int board_sum(int addrs [32], int n);
    longint sum;
    sum = 0;
    for (int i = 0; i < n; i++)
      if (weight_mem.exists(addrs[i])) sum += weight_mem[addrs[i]];
    return sat32(sum);
  endfunction

  // value of the board and, on a train step, the coherence update
  function automatic td_result_t td_predict(bit op, logic [39:0] lo, logic [39:0] hi,
                                            logic [23:0] rw, bit ep);
    td_result_t r;
    int code [16];
    int addrs [32];
    int cnt, f, pos, a;
    longint tgt, err, mv, e, ab, mag;
    logic [79:0] board;
    board = {hi, lo};
    for (int i = 0; i < 16; i++) begin
      code[i] = int'(board[5*i +: 5]);
      if (code[i] > 21) code[i] = 21;   // out-of-range code clamps
    end
    cnt = (count_q == 0) ? 1 : (count_q > 4) ? 4 : int'(count_q);
    for (int k = 0; k < cnt; k++)
      for (int s = 0; s < 8; s++) begin
        f = 0;
        for (int i = 0; i < 4; i++) begin
          pos = (int'(cells_q[k]) >> (4 * (3 - i))) & 15;
          f = f * 22 + code[sym_perm[s][pos]];
        end
        addrs[k*8+s] = k * SPAN_T + f;
      end
    r.before_v = board_sum(addrs, cnt * 8);
    r.after_v  = r.before_v;
    r.err_v    = 0;
    if (op && train_q) begin
      tgt = ep ? 0 : longint'(next_val_q) + (longint'(next_rw_q) << 16);
      err = sat32(tgt - r.before_v);
      r.err_v = int'((err * longint'(rate_q)) / (longint'(cnt) * 8 * 65536));
      mag = (r.err_v < 0) ? -longint'(r.err_v) : longint'(r.err_v);
      for (int n = 0; n < cnt * 8; n++) begin
        a  = addrs[n];
        e  = coh_err_mem.exists(a) ? coh_err_mem[a] : 0;
        ab = coh_abs_mem.exists(a) ? longint'(coh_abs_mem[a]) : 0;
        mv = r.err_v;
        if (ab != 0) mv = (longint'(r.err_v) * (e < 0 ? -e : e)) / ab;
        weight_mem[a]  = sat32((weight_mem.exists(a) ? weight_mem[a] : 0) + mv);
        coh_abs_mem[a] = (ab + mag > 64'hffffffff) ? 32'hffffffff : int'(ab + mag);
        coh_err_mem[a] = sat32(e + r.err_v);
      end
      r.after_v  = board_sum(addrs, cnt * 8);
      next_val_q = r.after_v;
      next_rw_q  = rw;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic reg_write(ntd_pkg::reg_idx_t idx, logic [31:0] v);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {idx, 2'b00}; pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      ntd_pkg::REG_LEARN_RATE:  rate_q  = v[15:0];
      ntd_pkg::REG_TUPLE_COUNT: count_q = v[2:0];
      ntd_pkg::REG_TRAIN_EN:    train_q = v[0];
      ntd_pkg::REG_CELLS_A:     cells_q[0] = v[15:0];
      ntd_pkg::REG_CELLS_B:     cells_q[1] = v[15:0];
      ntd_pkg::REG_CELLS_C:     cells_q[2] = v[15:0];
      ntd_pkg::REG_CELLS_D:     cells_q[3] = v[15:0];
      default: ;
    endcase
  endtask

  // one board transaction; called and returns at a falling edge
  task automatic send_board(bit op, logic [39:0] lo, logic [39:0] hi,
                            logic [23:0] rw, bit ep, bit fixed, td_result_t fx);
    td_result_t r;
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 15)) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 40);
    end
    burst_left--;
    in_if.valid = 1'b1; in_if.op = op; in_if.board_low = lo;
    in_if.board_high = hi; in_if.reward = rw; in_if.episode_end = ep;
    do @(posedge clk); while (!in_if.ready);
    r = td_predict(op, lo, hi, rw, ep);
    pending_q.insert(pending_q.size(), fixed ? fx : r);
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // mostly low codes so tuples revisit entries and coherence kicks in
  function automatic logic [39:0] rand_half();
    logic [39:0] h;
    for (int i = 0; i < 8; i++)
      h[5*i +: 5] = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 3))
                                                : 5'($urandom_range(0, 31));
    return h;
  endfunction

  function automatic logic [23:0] rand_reward();
    case ($urandom_range(0, 3))
      0: return 24'd0;
      1: return 24'($urandom_range(0, 16));
      2: return 24'($urandom_range(0, 4096));
      default: return 24'($urandom);
    endcase
  endfunction

  // episodes as the host sends them: final board first, then earlier ones
  task automatic random_phase(int n_items);
    int left, ep_len;
    td_result_t nil;
    nil = '{0, 0, 0};
    left = n_items;
    while (left > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        send_board(1'($urandom_range(0, 1)), 40'({$urandom, $urandom}),
                   40'({$urandom, $urandom}), 24'($urandom),
                   1'($urandom_range(0, 1)), 1'b0, nil);
        left--;
      end else begin
        ep_len = $urandom_range(2, 8);
        for (int i = 0; i < ep_len && left > 0; i++) begin
          if ($urandom_range(0, 4) == 0) begin
            send_board(1'b0, rand_half(), rand_half(), 24'($urandom), 1'b0, 1'b0, nil);
            left--;
          end
          send_board(1'b1, rand_half(), rand_half(), rand_reward(), i == 0, 1'b0, nil);
          left--;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: changing stall patterns, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int mode, span;
    out_if.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 300);
      for (int i = 0; i < span; i++) begin
        @(negedge clk);
        if (hold_req) begin
          out_if.ready = 1'b0;
          repeat (HOLD_CY) @(negedge clk);
          hold_req = 1'b0;
        end
        case (mode)
          0: out_if.ready = 1'b1;
          1: out_if.ready = ($urandom_range(0, 9) < 7);
          2: out_if.ready = i[2];
          default: out_if.ready = ($urandom_range(0, 9) < 2);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    td_result_t x;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction");
      end else begin
        x = pending_q.pop_front();
        if (out_if.value_before !== x.before_v || out_if.value_after !== x.after_v ||
            out_if.error_applied !== x.err_v) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                     x.before_v, x.after_v, x.err_v, out_if.value_before,
                     out_if.value_after, out_if.error_applied);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  stim_row_t rows [14] = '{
    // fresh tables: every board reads zero
    '{1'b0, 40'h0, 40'h0, 24'h0, 1'b0, 1'b1, '{0, 0, 0}},
    '{1'b0, 40'hff_ffff_ffff, 40'hff_ffff_ffff, 24'hffffff, 1'b1, 1'b1, '{0, 0, 0}},
    // final board of an episode against zero tables: no error
    '{1'b1, 40'h0, 40'h0, 24'h0, 1'b1, 1'b1, '{0, 0, 0}},
    // stored next value and reward are still zero
    '{1'b1, 40'h08_4210_8421, 40'h08_4210_8421, 24'hffffff, 1'b0, 1'b1, '{0, 0, 0}},
    // max reward stored: error saturates
    '{1'b1, 40'h0, 40'h0, 24'h0, 1'b0, 1'b0, '{0, 0, 0}},
    '{1'b1, 40'h0, 40'h0, 24'h1, 1'b0, 1'b0, '{0, 0, 0}},
    '{1'b1, 40'h0, 40'h0, 24'h0, 1'b1, 1'b0, '{0, 0, 0}},
    '{1'b0, 40'h0, 40'h0, 24'h0, 1'b0, 1'b0, '{0, 0, 0}},
    // codes 26 and 31 both land on the top digit
    '{1'b1, 40'h56_b5ad_6b5a, 40'hff_ffff_ffff, 24'h000100, 1'b0, 1'b0, '{0, 0, 0}},
    '{1'b0, 40'hff_ffff_ffff, 40'h56_b5ad_6b5a, 24'h0, 1'b0, 1'b0, '{0, 0, 0}},
    '{1'b1, 40'h08_4210_8421, 40'h0, 24'h000010, 1'b0, 1'b0, '{0, 0, 0}},
    '{1'b1, 40'h08_4210_8421, 40'h0, 24'h000010, 1'b0, 1'b0, '{0, 0, 0}},
    '{1'b1, 40'h0, 40'h08_4210_8421, 24'h0, 1'b1, 1'b0, '{0, 0, 0}},
    '{1'b0, 40'h08_4210_8421, 40'h0, 24'h0, 1'b1, 1'b0, '{0, 0, 0}}
  };

  initial begin
    in_if.valid = 1'b0; in_if.op = 1'b0; in_if.board_low = '0;
    in_if.board_high = '0; in_if.reward = '0; in_if.episode_end = 1'b0;
    build_sym_perm();
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // directed rows at reset configuration; the clearing pass gates the first
    foreach (rows[i])
      send_board(rows[i].op, rows[i].lo, rows[i].hi, rows[i].rw, rows[i].ep,
                 rows[i].fixed, rows[i].res);
    random_phase(350);
    drain();

    // fastest rate, one tuple; long receiver hold-off fills the block
    reg_write(ntd_pkg::REG_LEARN_RATE, 32'hffff);
    reg_write(ntd_pkg::REG_TUPLE_COUNT, 32'd1);
    hold_req = 1'b1;
    random_phase(350);
    drain();

    // count 0 acts as one tuple; training off
    reg_write(ntd_pkg::REG_TUPLE_COUNT, 32'd0);
    reg_write(ntd_pkg::REG_TRAIN_EN, 32'd0);
    random_phase(250);
    drain();

    // count above range acts as four; zero rate, then random tuple shapes
    reg_write(ntd_pkg::REG_TRAIN_EN, 32'd1);
    reg_write(ntd_pkg::REG_TUPLE_COUNT, 32'd7);
    reg_write(ntd_pkg::REG_LEARN_RATE, 32'd0);
    reg_write(ntd_pkg::REG_CELLS_A, 32'h0000);
    reg_write(ntd_pkg::REG_CELLS_B, 32'hffff);
    random_phase(200);
    drain();

    reg_write(ntd_pkg::REG_LEARN_RATE, $urandom_range(1, 65535));
    reg_write(ntd_pkg::REG_TUPLE_COUNT, $urandom_range(2, 3));
    reg_write(ntd_pkg::REG_CELLS_A, $urandom);
    reg_write(ntd_pkg::REG_CELLS_B, $urandom);
    reg_write(ntd_pkg::REG_CELLS_C, $urandom);
    reg_write(ntd_pkg::REG_CELLS_D, $urandom);
    random_phase(350);
    drain();

    // back to the reset shapes with a mid-range rate
    reg_write(ntd_pkg::REG_TUPLE_COUNT, 32'd4);
    reg_write(ntd_pkg::REG_LEARN_RATE, 32'd6554);
    reg_write(ntd_pkg::REG_CELLS_A, 32'(ntd_pkg::RST_CELLS_A));
    reg_write(ntd_pkg::REG_CELLS_B, 32'(ntd_pkg::RST_CELLS_B));
    reg_write(ntd_pkg::REG_CELLS_C, 32'(ntd_pkg::RST_CELLS_C));
    reg_write(ntd_pkg::REG_CELLS_D, 32'(ntd_pkg::RST_CELLS_D));
    random_phase(386);

    while (pending_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (mismatches == 0 && pending_q.size() == 0)
      $display("ntuple_td_value_engine test passed");
    else
      $display("ntuple_td_value_engine test failed");
    $finish;
  end

endmodule

### sim.f
src/ntd_pkg.sv
src/ntd_if.sv
src/ntd_cfg.sv
src/ntd_div.sv
src/ntd_dp.sv
src/ntd_ctrl.sv
src/ntuple_td_value_engine.sv
sim/ntuple_td_value_engine_tb.sv
